// ===== hw/rtl/http_chunked_body_deframer_defines.svh =====
// Assertion helpers shared by the deframer RTL.
`ifndef HTTP_CHUNKED_BODY_DEFRAMER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam logic       KIND_DATA     = 1'b0;
    localparam logic       KIND_REPORT   = 1'b1;

    localparam logic [1:0] END_NORMAL    = 2'd0;
    localparam logic [1:0] END_OVERFLOW  = 2'd1;
    localparam logic [1:0] END_TRUNCATED = 2'd2;

    localparam logic [7:0] CR_BYTE       = 8'h0D;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       chunk_last;
        logic [1:0] end_reason;
        logic       run_last;
    } t_result;

    // Up to two results per accepted byte: payload first, report second.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // {valid, value}: valid is set for 0-9, a-f, A-F.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/http_chunked_body_deframer.sv =====
`timescale 1ns / 1ps

// HTTP chunked body deframer. Takes a message body one byte per transaction
// (tlast on the final byte) and emits payload bytes and one end-of-body report
// per body. A byte is taken when the result queue has room; its results are
// written to that queue and shown on the master side from there. Throughput
// is one byte per clock while each byte gives at most one result and the
// master side does not stall; a byte giving a payload byte plus the report
// (final byte in plain mode or in chunk data) gives two results, absorbed by
// the four-entry queue; input stalls only when fewer than two entries are free.
// i_cfg_wdata = 1 (reset value) decodes chunked coding, 0 passes the body as
// one chunk; write it only while the block is idle. No init sweep after reset.
module http_chunked_body_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
    input  logic        s_axis_tlast,   // body_last

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] end_reason, [10] run_last
    output logic        m_axis_tlast,   // chunk_last
    output logic        m_axis_tuser    // kind
);
    import hcbd_pkg::*;

    t_push   push;
    t_result result;
    logic    room;

    hcbd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_room      (room),
        .o_ready     (s_axis_tready),
        .o_push      (push)
    );

    hcbd_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {5'd0, result.run_last, result.end_reason, result.data_byte};
    assign m_axis_tlast = result.chunk_last;
    assign m_axis_tuser = result.kind;

endmodule

// ===== hw/rtl/hcbd_core.sv =====
`timescale 1ns / 1ps
`include "http_chunked_body_deframer_defines.svh"

module hcbd_core #(
    parameter int LENGTH_BITS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  logic            i_room,
    output logic            o_ready,
    output hcbd_pkg::t_push o_push
);
    import hcbd_pkg::*;

    localparam logic [2:0] PH_HEX      = 3'd0;
    localparam logic [2:0] PH_SEEK_CR  = 3'd1;
    localparam logic [2:0] PH_SKIP_ONE = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_TRAIL_A  = 3'd4;
    localparam logic [2:0] PH_TRAIL_B  = 3'd5;

    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

    logic                   r_chunked_mode;
    logic [2:0]             r_phase,     n_phase;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic                   r_finished,  n_finished;

    logic                   accept;
    logic [4:0]             hex;
    logic                   is_cr;
    logic [LENGTH_BITS-1:0] rem_shift;
    logic                   pay_v;
    logic                   pay_clast;
    logic                   rep_v;
    logic [1:0]             rep_reason;
    t_result                pay_res;
    t_result                rep_res;

    assign o_ready   = i_room;
    assign accept    = i_valid & i_room;
    assign hex       = hex_digit(i_byte);
    assign is_cr     = (i_byte == CR_BYTE);
    assign rem_shift = {r_remaining[LENGTH_BITS-5:0], hex[3:0]};

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_finished  = r_finished;
        pay_v       = 1'b0;
        pay_clast   = 1'b0;
        rep_v       = 1'b0;
        rep_reason  = END_NORMAL;

        if (!r_finished) begin
            if (!r_chunked_mode) begin
                pay_v     = 1'b1;
                pay_clast = i_last;
                rep_v     = i_last;
            end else begin
                unique case (r_phase)
                    PH_HEX: begin
                        if (hex[4]) begin
                            if (r_remaining[LENGTH_BITS-1 -: 4] != 4'd0) begin
                                rep_v      = 1'b1;
                                rep_reason = END_OVERFLOW;
                            end else begin
                                n_remaining = rem_shift;
                                if (i_last) begin
                                    rep_v      = 1'b1;
                                    rep_reason = (rem_shift == LEN_ZERO) ? END_NORMAL
                                                                         : END_TRUNCATED;
                                end
                            end
                        end else if (r_remaining == LEN_ZERO) begin
                            // non-hex header or explicit zero: clean end
                            rep_v = 1'b1;
                        end else begin
                            n_phase = is_cr ? PH_SKIP_ONE : PH_SEEK_CR;
                        end
                    end
                    PH_SEEK_CR: begin
                        if (is_cr) begin
                            n_phase = PH_SKIP_ONE;
                        end
                    end
                    PH_SKIP_ONE: begin
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        pay_v       = 1'b1;
                        pay_clast   = (r_remaining == LEN_ONE);
                        n_remaining = r_remaining - LEN_ONE;
                        if (r_remaining == LEN_ONE) begin
                            n_phase = PH_TRAIL_A;
                        end
                    end
                    PH_TRAIL_A: begin
                        n_phase = PH_TRAIL_B;
                    end
                    default: begin
                        n_phase     = PH_HEX;
                        n_remaining = LEN_ZERO;
                        rep_v       = i_last;
                    end
                endcase
                if (i_last && !rep_v) begin
                    rep_v      = 1'b1;
                    rep_reason = END_TRUNCATED;
                end
            end
            if (rep_v) begin
                n_finished = 1'b1;
            end
        end

        // the flagged final byte always returns the parser to its start
        if (i_last) begin
            n_phase     = PH_HEX;
            n_remaining = LEN_ZERO;
            n_finished  = 1'b0;
        end
    end

    always_comb begin
        pay_res.kind       = KIND_DATA;
        pay_res.data_byte  = i_byte;
        pay_res.chunk_last = pay_clast;
        pay_res.end_reason = END_NORMAL;
        pay_res.run_last   = ~rep_v;

        rep_res.kind       = KIND_REPORT;
        rep_res.data_byte  = 8'd0;
        rep_res.chunk_last = 1'b0;
        rep_res.end_reason = rep_reason;
        rep_res.run_last   = 1'b1;

        o_push.count = accept ? ({1'b0, pay_v} + {1'b0, rep_v}) : 2'd0;
        o_push.res0  = pay_v ? pay_res : rep_res;
        o_push.res1  = rep_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_chunked_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEX;
            r_remaining <= LEN_ZERO;
            r_finished  <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_finished  <= n_finished;
        end
    end

    `HCBD_ASSERT_NOW(a_finished_silent, i_clk, i_rst_n, r_finished, o_push.count == 2'd0,
        "byte produced results after end of body")
    `HCBD_ASSERT_NOW(a_phase_legal, i_clk, i_rst_n, 1'b1, r_phase <= PH_TRAIL_B,
        "parser phase out of range")
    `HCBD_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, accept && i_last,
        r_phase == PH_HEX && r_remaining == LEN_ZERO && !r_finished,
        "final body byte did not clear the parser")

endmodule

// ===== hw/rtl/hcbd_result_queue.sv =====
`timescale 1ns / 1ps
`include "http_chunked_body_deframer_defines.svh"

module hcbd_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcbd_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output hcbd_pkg::t_result o_result
);
    import hcbd_pkg::*;

    localparam logic [QUEUE_CNT_BITS-1:0] ROOM_LIMIT = QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

    t_result                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count,  n_count;
    logic                      pop;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;

    assign o_room      = (r_count <= ROOM_LIMIT);
    assign o_valid     = (r_count != '0);
    assign o_result    = r_entry[r_rd_ptr];
    assign pop         = o_valid & i_ready;
    assign wr_ptr_next = r_wr_ptr + QUEUE_PTR_BITS'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_PTR_BITS'(i_push.count);
        n_rd_ptr = r_rd_ptr + QUEUE_PTR_BITS'(pop);
        n_count  = r_count + QUEUE_CNT_BITS'(i_push.count) - QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_entry[wr_ptr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `HCBD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "result queue count beyond depth")
    `HCBD_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, i_push.count != 2'd0, o_room,
        "results pushed without room for two")
    `HCBD_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && i_push.count == 2'd0,
        r_count == $past(r_count) - QUEUE_CNT_BITS'(1), "pop did not drain the queue")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import hcbd_pkg::*;

    localparam int PREDICT      = -1;    // row result comes from the parser model
    localparam int RAND_ITEMS   = 1950;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 8;
    localparam int WATCHDOG     = 4000;

    localparam t_result RPT_NORMAL   = '{KIND_REPORT, 8'h00, 1'b0, END_NORMAL, 1'b1};
    localparam t_result RPT_OVERFLOW = '{KIND_REPORT, 8'h00, 1'b0, END_OVERFLOW, 1'b1};

    typedef enum logic [2:0] {
        P_LENGTH, P_SEEK_CR, P_SKIP_LF, P_DATA, P_TRAIL_CR, P_TRAIL_LF
    } t_parse;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} t_rx_style;

    typedef struct {
        logic [7:0] b;
        logic       last;
        int         typed;
        t_result    want;
    } t_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b1;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = 8'h00;
    logic        s_last    = 1'b0;
    logic        m_ready   = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;   // [7:0] data_byte, [9:8] end_reason, [10] run_last
    logic        m_axis_tlast;   // chunk_last
    logic        m_axis_tuser;   // kind

    // parser model state
    t_parse      parse_st     = P_LENGTH;
    logic [63:0] bytes_due    = '0;
    logic        body_over    = 1'b0;
    logic        mode_chunked = 1'b1;
    t_result     step_out[$];
    t_result     deframed_q[$];

    logic [7:0]  frame[$];
    int          errors       = 0;
    int          useful_items = 0;
    int          burst_left   = 0;
    bit          steady_send  = 1'b0;
    int          hold_asks    = 0;

    http_chunked_body_deframer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Chunked mode at reset. Typed rows hold results that are obvious by inspection.
    t_row script [0:26] = '{
        '{"0",   1'b1, 1,       RPT_NORMAL},    // zero length right at the end
        '{"G",   1'b0, 1,       RPT_NORMAL},    // non-hex first byte reads as zero
        '{8'hFF, 1'b1, 0,       '0},            // ignored until the last byte
        '{"1",   1'b0, PREDICT, '0},
        '{"a",   1'b0, PREDICT, '0},
        '{"b",   1'b0, PREDICT, '0},
        '{"c",   1'b0, PREDICT, '0},
        '{"d",   1'b0, PREDICT, '0},
        '{"e",   1'b0, PREDICT, '0},
        '{"f",   1'b0, PREDICT, '0},
        '{"A",   1'b0, PREDICT, '0},
        '{"B",   1'b0, PREDICT, '0},
        '{"C",   1'b0, PREDICT, '0},
        '{"D",   1'b0, PREDICT, '0},
        '{"E",   1'b0, PREDICT, '0},
        '{"F",   1'b0, PREDICT, '0},
        '{"0",   1'b0, PREDICT, '0},
        '{"9",   1'b0, PREDICT, '0},
        '{"8",   1'b0, PREDICT, '0},
        '{"7",   1'b0, 1,       RPT_OVERFLOW},  // 17th digit with a nonzero top nibble
        '{8'h00, 1'b1, 0,       '0},
        '{"2",   1'b0, PREDICT, '0},
        '{";",   1'b0, PREDICT, '0},            // extension, skipped up to CR
        '{8'h0D, 1'b0, PREDICT, '0},
        '{8'h0A, 1'b0, PREDICT, '0},
        '{8'h00, 1'b0, PREDICT, '0},
        '{8'hFF, 1'b1, PREDICT, '0}             // last payload byte, then truncation report
    };

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] lc;
        lc = b | 8'h20;
        if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
        if (lc >= 8'h61 && lc <= 8'h66) return {1'b1, lc[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic t_result report(input logic [1:0] reason);
        t_result r;
        r = '0;
        r.kind = KIND_REPORT;
        r.end_reason = reason;
        return r;
    endfunction

    function automatic t_result payload(input logic [7:0] b, input logic clast);
        t_result r;
        r = '0;
        r.kind = KIND_DATA;
        r.data_byte = b;
        r.chunk_last = clast;
        return r;
    endfunction

    function automatic void restart_body();
        parse_st  = P_LENGTH;
        bytes_due = '0;
        body_over = 1'b0;
    endfunction

    // Results caused by one body byte go to step_out.
    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        logic [4:0] nib;
        logic       ended;
        step_out.delete();
        ended = 1'b0;
        nib = hex_nibble(b);
        if (body_over) begin
            if (last) restart_body();
            return;
        end
        if (!mode_chunked) begin
            step_out.push_back(payload(b, last));
            if (last) begin
                step_out.push_back(report(END_NORMAL));
                ended = 1'b1;
            end
        end else begin
            case (parse_st)
                P_LENGTH: begin
                    if (nib[4]) begin
                        if (bytes_due[63:60] != 4'd0) begin
                            step_out.push_back(report(END_OVERFLOW));
                            ended = 1'b1;
                        end else begin
                            bytes_due = {bytes_due[59:0], nib[3:0]};
                            if (last) begin
                                step_out.push_back(report(bytes_due == 0 ? END_NORMAL
                                                                         : END_TRUNCATED));
                                ended = 1'b1;
                            end
                        end
                    end else if (bytes_due == 0) begin
                        step_out.push_back(report(END_NORMAL));
                        ended = 1'b1;
                    end else begin
                        // the terminating byte may itself be the CR
                        parse_st = (b == CR_BYTE) ? P_SKIP_LF : P_SEEK_CR;
                        if (last) begin
                            step_out.push_back(report(END_TRUNCATED));
                            ended = 1'b1;
                        end
                    end
                end
                P_SEEK_CR: if (b == CR_BYTE) parse_st = P_SKIP_LF;
                P_SKIP_LF: parse_st = P_DATA;
                P_DATA: begin
                    step_out.push_back(payload(b, bytes_due == 64'd1));
                    bytes_due = bytes_due - 64'd1;
                    if (bytes_due == 0) parse_st = P_TRAIL_CR;
                end
                P_TRAIL_CR: parse_st = P_TRAIL_LF;
                default: begin
                    parse_st  = P_LENGTH;
                    bytes_due = '0;
                    if (last) begin
                        step_out.push_back(report(END_NORMAL));
                        ended = 1'b1;
                    end
                end
            endcase
            if (last && !ended) begin
                step_out.push_back(report(END_TRUNCATED));
                ended = 1'b1;
            end
        end
        if (last) restart_body();
        else if (ended) body_over = 1'b1;
        if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input int typed = PREDICT, input t_result want = '0);
        int   gap;
        logic was_ignored;
        if (burst_left == 0) begin
            gap = (steady_send || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        do @(posedge clk); while (!s_axis_tready);
        was_ignored = body_over;
        deframe_byte(b, last);
        if (typed == PREDICT) begin
            foreach (step_out[i]) deframed_q.push_back(step_out[i]);
        end else if (typed == 1) begin
            deframed_q.push_back(want);
        end
        if (!was_ignored) useful_items++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (deframed_q.size() != 0);
    endtask

    task automatic set_mode(input logic chunked);
        drain_results();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= chunked;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_chunked = chunked;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic void push_hex(input int unsigned v);
        bit started;
        started = 1'b0;
        for (int s = 28; s >= 0; s -= 4) begin
            if (((v >> s) & 15) != 0 || started || s == 0) begin
                started = 1'b1;
                frame.push_back(hex_char(4'((v >> s) & 15)));
            end
        end
    endfunction

    function automatic void build_plain();
        int len;
        frame.delete();
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
        repeat (len) frame.push_back(8'($urandom));
    endfunction

    function automatic void build_chunked();
        int         form;
        int         chunks;
        int         len;
        int         ending;
        logic [7:0] x;
        frame.delete();
        form = $urandom_range(0, 9);
        if (form <= 5) begin
            // chunks of random content, some with random bytes for LF or CRLF, and a random way of ending
            chunks = $urandom_range(0, 3);
            repeat (chunks) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(1, 12);
                repeat ($urandom_range(0, 2)) frame.push_back("0");
                push_hex(len);
                if ($urandom_range(0, 3) == 0) begin
                    frame.push_back(";");
                    repeat ($urandom_range(0, 3)) begin
                        x = 8'($urandom);
                        frame.push_back(x == CR_BYTE ? 8'h20 : x);
                    end
                end
                frame.push_back(CR_BYTE);
                frame.push_back($urandom_range(0, 4) == 0 ? 8'($urandom) : 8'h0A);
                repeat (len) frame.push_back(8'($urandom));
                if ($urandom_range(0, 4) == 0) begin
                    frame.push_back(8'($urandom));
                    frame.push_back(8'($urandom));
                end else begin
                    frame.push_back(CR_BYTE);
                    frame.push_back(8'h0A);
                end
            end
            ending = $urandom_range(0, 2);
            if (ending == 0 || frame.size() == 0) begin
                frame.push_back("0");
                if ($urandom_range(0, 1)) begin
                    frame.push_back(CR_BYTE);
                    frame.push_back(8'h0A);
                    frame.push_back(CR_BYTE);
                    frame.push_back(8'h0A);
                end
            end else if (ending == 2 && frame.size() > 1) begin
                // cut short anywhere before the last byte of the frame
                frame = frame[0:$urandom_range(0, frame.size() - 2)];
            end
        end else if (form == 6) begin
            frame.push_back(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(16, 19)) frame.push_back(hex_char(4'($urandom)));
            repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
        end else if (form == 7) begin
            repeat ($urandom_range(1, 4)) frame.push_back("0");
            repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0: frame.push_back(hex_char(4'($urandom)));
                    1: frame.push_back($urandom_range(0, 1) ? CR_BYTE : 8'h0A);
                    default: frame.push_back(8'($urandom));
                endcase
            end
        end
    endfunction

    task automatic send_frame();
        foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endfunction

    // receiver: checks each result transaction and stalls on its own pattern
    int          hold_left = 0;
    int          holds_seen = 0;
    int          span_left = 0;
    int unsigned rx_tick = 0;
    int          rx_period = 2;
    t_rx_style   rx_style = RX_OPEN;

    always @(posedge clk) begin : rx_side
        t_result want;
        if (m_axis_tvalid && m_ready) begin
            if (deframed_q.size() == 0) begin
                $error("result with nothing expected: tdata %h tlast %b tuser %b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end else begin
                want = deframed_q.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
                check_field("chunk_last", want.chunk_last, m_axis_tlast);
                check_field("end_reason", want.end_reason, m_axis_tdata[9:8]);
                check_field("run_last", want.run_last, m_axis_tdata[10]);
            end
        end
        if (hold_asks != holds_seen) begin
            holds_seen = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (span_left == 0) begin
                rx_style  = t_rx_style'($urandom_range(0, 2));
                span_left = $urandom_range(40, 300);
                rx_period = $urandom_range(2, 6);
            end
            span_left--;
            rx_tick++;
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                default:   m_ready <= (rx_tick % rx_period) != 0;
            endcase
        end
    end

    int idle_cycles = 0;

    always @(posedge clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic next_mode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) send_byte(script[i].b, script[i].last, script[i].typed,
                                      script[i].want);

        useful_items = 0;
        for (int p = 0; p < PHASES; p++) begin
            next_mode = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            set_mode(next_mode);
            if (p == 0) begin
                // output held off while bytes keep coming, so the input backs up
                steady_send = 1'b1;
                hold_asks++;
                for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 39);
                steady_send = 1'b0;
                drain_results();
            end
            while (useful_items < (p + 1) * RAND_ITEMS / PHASES) begin
                if (mode_chunked) build_chunked();
                else build_plain();
                send_frame();
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
